[rtl/smd_pkg.sv]
// Package for the serial message deframer: phase and event codes,
// configuration register indexes and reset values.
// No dependencies.
package smd_pkg;

  // Frame parsing phase
  typedef enum logic [2:0] {
    PH_IDLE   = 3'd0,
    PH_HUNT   = 3'd1,
    PH_SEQ    = 3'd2,
    PH_LEN_HI = 3'd3,
    PH_LEN_LO = 3'd4,
    PH_TOKEN  = 3'd5,
    PH_DATA   = 3'd6,
    PH_CHECK  = 3'd7
  } phase_t;

  // Result event codes
  typedef enum logic [2:0] {
    EV_NONE    = 3'd0,
    EV_DATA    = 3'd1,
    EV_OK      = 3'd2,
    EV_CSUM    = 3'd3,
    EV_HDR     = 3'd4,
    EV_TIMEOUT = 3'd5,
    EV_HUNT    = 3'd6
  } event_t;

  // Configuration register indexes
  localparam logic [2:0] CFG_START_BYTE   = 3'd0;
  localparam logic [2:0] CFG_TOKEN_BYTE   = 3'd1;
  localparam logic [2:0] CFG_IDLE_TIMEOUT = 3'd2;
  localparam logic [2:0] CFG_HUNT_LIMIT   = 3'd3;
  localparam logic [2:0] CFG_MAX_PAYLOAD  = 3'd4;

  // Configuration reset values
  localparam logic [7:0]  START_BYTE_RST   = 8'd27;
  localparam logic [7:0]  TOKEN_BYTE_RST   = 8'd14;
  localparam logic [15:0] IDLE_TIMEOUT_RST = 16'd1000;
  localparam logic [8:0]  HUNT_LIMIT_RST   = 9'd300;
  localparam logic [15:0] MAX_PAYLOAD_RST  = 16'd285;

  // Sequence number expected at session start
  localparam logic [7:0] SEQ_FIRST = 8'd1;

endpackage

[rtl/serial_message_deframer.sv]
// Serial message deframer top level: byte-stream frame parser with
// sequence, length, token and XOR checksum checks. Depends on smd_pkg.
//
// Usage: each input item is either a received byte (in_mode = 0) or a
// one-millisecond tick without data (in_mode = 1). Every accepted input item
// yields exactly one result item: an event code with the payload byte and
// its index (payload events only), the current frame sequence number and the
// announced payload length.
// The result is registered: the result of an item accepted at one edge is shown
// on out_* from that edge on. One item per cycle is sustained while out_stall
// is low; the phase, checksum and counter updates are combinational and are
// registered at the same edge as the result register.
// The result register is the only buffer: while it holds an item and
// out_stall is high, in_stall is raised and the input is held off.
// Synchronous active-low reset returns the parser to idle outside a session,
// empties the result register and restores all configuration registers to
// their defaults. Configuration writes are taken in any cycle (cfg_ready is
// always high); indexes beyond the register list are ignored.
module serial_message_deframer (
  input  logic        clk,
  input  logic        rst_n,
  // Input channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_mode,
  input  logic [7:0]  in_rx_byte,
  // Result channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  out_event_res,
  output logic [7:0]  out_payload_byte,
  output logic [15:0] out_payload_index,
  output logic [7:0]  out_frame_seq,
  output logic [15:0] out_frame_length,
  // Configuration write channel
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  // Configuration registers
  logic [7:0]  start_byte_r;
  logic [7:0]  token_byte_r;
  logic [15:0] idle_timeout_r;
  logic [8:0]  hunt_limit_r;
  logic [15:0] max_payload_r;

  // Parser state
  smd_pkg::phase_t phase_r, phase_nxt;
  logic [7:0]  exp_seq_r, exp_seq_nxt;
  logic [7:0]  run_xor_r, run_xor_nxt;
  logic [15:0] ann_len_r, ann_len_nxt;
  logic [15:0] byte_idx_r, byte_idx_nxt;
  logic [8:0]  hunt_cnt_r, hunt_cnt_nxt;
  logic [15:0] idle_cnt_r, idle_cnt_nxt;

  // Result register
  logic        out_valid_r, out_valid_nxt;
  smd_pkg::event_t ev_r, ev_nxt;
  logic [7:0]  pbyte_r, pbyte_nxt;
  logic [15:0] pidx_r, pidx_nxt;
  logic [7:0]  seq_out_r, seq_out_nxt;
  logic [15:0] len_out_r;

  logic        in_acc;
  logic        is_tick;
  logic        is_start;
  logic [16:0] idle_inc;
  logic        timeout;
  logic        hunt_over;
  logic        seq_ok;
  logic [15:0] len_full;
  logic        len_bad;
  logic        tok_ok;
  logic [15:0] idx_inc;
  logic        last_data;
  logic        csum_ok;

  // Handshakes
  assign in_stall  = out_valid_r & out_stall;
  assign in_acc    = in_valid & ~in_stall;
  assign cfg_ready = 1'b1;

  // Decode of the current item against the state
  assign is_tick   = in_mode;
  assign is_start  = (in_rx_byte == start_byte_r);
  assign idle_inc  = {1'b0, idle_cnt_r} + 17'd1;
  assign timeout   = idle_inc[16] | (idle_inc[15:0] >= idle_timeout_r);
  assign hunt_over = (hunt_cnt_r >= hunt_limit_r);
  assign seq_ok    = (in_rx_byte == smd_pkg::SEQ_FIRST) || (in_rx_byte == exp_seq_r);
  assign len_full  = {ann_len_r[15:8], in_rx_byte};
  assign len_bad   = (len_full == 16'd0) || (len_full > max_payload_r);
  assign tok_ok    = (in_rx_byte == token_byte_r);
  assign idx_inc   = byte_idx_r + 16'd1;
  assign last_data = (idx_inc == ann_len_r);
  assign csum_ok   = (in_rx_byte == run_xor_r);

  // Next phase
  always_comb begin
    phase_nxt = phase_r;
    if (phase_r == smd_pkg::PH_IDLE) begin
      if (!is_tick && is_start) begin
        phase_nxt = smd_pkg::PH_SEQ;
      end
    end else if (is_tick) begin
      if (timeout) begin
        phase_nxt = smd_pkg::PH_IDLE;
      end
    end else begin
      case (phase_r)
        smd_pkg::PH_HUNT: begin
          if (is_start) begin
            phase_nxt = smd_pkg::PH_SEQ;
          end else if (hunt_over) begin
            phase_nxt = smd_pkg::PH_IDLE;
          end
        end
        smd_pkg::PH_SEQ:    phase_nxt = seq_ok ? smd_pkg::PH_LEN_HI : smd_pkg::PH_HUNT;
        smd_pkg::PH_LEN_HI: phase_nxt = smd_pkg::PH_LEN_LO;
        smd_pkg::PH_LEN_LO: phase_nxt = len_bad ? smd_pkg::PH_HUNT : smd_pkg::PH_TOKEN;
        smd_pkg::PH_TOKEN:  phase_nxt = tok_ok ? smd_pkg::PH_DATA : smd_pkg::PH_HUNT;
        smd_pkg::PH_DATA: begin
          if (last_data) begin
            phase_nxt = smd_pkg::PH_CHECK;
          end
        end
        default:            phase_nxt = smd_pkg::PH_HUNT;
      endcase
    end
  end

  // Datapath state and result fields
  always_comb begin
    exp_seq_nxt  = exp_seq_r;
    run_xor_nxt  = run_xor_r;
    ann_len_nxt  = ann_len_r;
    byte_idx_nxt = byte_idx_r;
    hunt_cnt_nxt = hunt_cnt_r;
    idle_cnt_nxt = idle_cnt_r;
    ev_nxt       = smd_pkg::EV_NONE;
    pbyte_nxt    = 8'd0;
    pidx_nxt     = 16'd0;
    if (phase_r == smd_pkg::PH_IDLE) begin
      if (!is_tick && is_start) begin
        exp_seq_nxt  = smd_pkg::SEQ_FIRST;
        idle_cnt_nxt = 16'd0;
        run_xor_nxt  = start_byte_r;
        hunt_cnt_nxt = 9'd0;
      end
    end else if (is_tick) begin
      idle_cnt_nxt = idle_inc[15:0];
      if (timeout) begin
        idle_cnt_nxt = 16'd0;
        hunt_cnt_nxt = 9'd0;
        ev_nxt       = smd_pkg::EV_TIMEOUT;
      end
    end else begin
      idle_cnt_nxt = 16'd0;
      case (phase_r)
        smd_pkg::PH_HUNT: begin
          if (is_start) begin
            run_xor_nxt  = start_byte_r;
            hunt_cnt_nxt = 9'd0;
          end else if (hunt_over) begin
            hunt_cnt_nxt = 9'd0;
            ev_nxt       = smd_pkg::EV_HUNT;
          end else begin
            hunt_cnt_nxt = hunt_cnt_r + 9'd1;
          end
        end
        smd_pkg::PH_SEQ: begin
          if (seq_ok) begin
            exp_seq_nxt = in_rx_byte;
            run_xor_nxt = run_xor_r ^ in_rx_byte;
          end else begin
            ev_nxt = smd_pkg::EV_HDR;
          end
        end
        smd_pkg::PH_LEN_HI: begin
          ann_len_nxt = {in_rx_byte, 8'd0};
          run_xor_nxt = run_xor_r ^ in_rx_byte;
        end
        smd_pkg::PH_LEN_LO: begin
          ann_len_nxt = len_full;
          run_xor_nxt = run_xor_r ^ in_rx_byte;
          if (len_bad) begin
            ev_nxt = smd_pkg::EV_HDR;
          end
        end
        smd_pkg::PH_TOKEN: begin
          if (tok_ok) begin
            run_xor_nxt  = run_xor_r ^ in_rx_byte;
            byte_idx_nxt = 16'd0;
          end else begin
            ev_nxt = smd_pkg::EV_HDR;
          end
        end
        smd_pkg::PH_DATA: begin
          ev_nxt       = smd_pkg::EV_DATA;
          pbyte_nxt    = in_rx_byte;
          pidx_nxt     = byte_idx_r;
          run_xor_nxt  = run_xor_r ^ in_rx_byte;
          byte_idx_nxt = idx_inc;
        end
        default: begin
          if (csum_ok) begin
            ev_nxt      = smd_pkg::EV_OK;
            exp_seq_nxt = exp_seq_r + 8'd1;
          end else begin
            ev_nxt = smd_pkg::EV_CSUM;
          end
        end
      endcase
    end
    // An accepted frame reports the sequence number it carried
    seq_out_nxt = (ev_nxt == smd_pkg::EV_OK) ? exp_seq_r : exp_seq_nxt;
  end

  // Result register occupancy
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (in_acc) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_byte_r   <= smd_pkg::START_BYTE_RST;
      token_byte_r   <= smd_pkg::TOKEN_BYTE_RST;
      idle_timeout_r <= smd_pkg::IDLE_TIMEOUT_RST;
      hunt_limit_r   <= smd_pkg::HUNT_LIMIT_RST;
      max_payload_r  <= smd_pkg::MAX_PAYLOAD_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        smd_pkg::CFG_START_BYTE:   start_byte_r   <= cfg_data[7:0];
        smd_pkg::CFG_TOKEN_BYTE:   token_byte_r   <= cfg_data[7:0];
        smd_pkg::CFG_IDLE_TIMEOUT: idle_timeout_r <= cfg_data;
        smd_pkg::CFG_HUNT_LIMIT:   hunt_limit_r   <= cfg_data[8:0];
        smd_pkg::CFG_MAX_PAYLOAD:  max_payload_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  // Parser state, updated once per accepted item
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= smd_pkg::PH_IDLE;
      exp_seq_r  <= smd_pkg::SEQ_FIRST;
      run_xor_r  <= 8'd0;
      ann_len_r  <= 16'd0;
      byte_idx_r <= 16'd0;
      hunt_cnt_r <= 9'd0;
      idle_cnt_r <= 16'd0;
    end else if (in_acc) begin
      phase_r    <= phase_nxt;
      exp_seq_r  <= exp_seq_nxt;
      run_xor_r  <= run_xor_nxt;
      ann_len_r  <= ann_len_nxt;
      byte_idx_r <= byte_idx_nxt;
      hunt_cnt_r <= hunt_cnt_nxt;
      idle_cnt_r <= idle_cnt_nxt;
    end
  end

  // Result register: valid flag under reset, payload loaded on accept
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      ev_r      <= ev_nxt;
      pbyte_r   <= pbyte_nxt;
      pidx_r    <= pidx_nxt;
      seq_out_r <= seq_out_nxt;
      len_out_r <= ann_len_nxt;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_event_res     = ev_r;
  assign out_payload_byte  = pbyte_r;
  assign out_payload_index = pidx_r;
  assign out_frame_seq     = seq_out_r;
  assign out_frame_length  = len_out_r;

endmodule
